// File: rtl/rfps_pkg.sv
// Shared types, register codes and the color palette of the rainbow fade pixel shifter.
// No dependencies; every RTL file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rfps_pkg;

    localparam int NUM_PIXELS_DEF = 30;

    localparam int PIX_IDX_W = 6;
    localparam int LEVEL_W   = 8;
    localparam int RGB_W     = 3 * LEVEL_W;
    localparam int SEG_W     = 6;
    localparam int STEP_W    = 8;
    localparam int PAL_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [SEG_W-1:0]  SEG_LEN_RST   = 6'd15;
    localparam logic [STEP_W-1:0] FADE_STEP_RST = 8'd4;
    localparam logic [PAL_W-1:0]  PAL_IDX_RST   = 3'd1;
    localparam logic [SEG_W-1:0]  FRAME_CNT_RST = 6'd1;
    localparam logic [SEG_W-1:0]  FRAME_CNT_TOP = 6'd63;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP = 1'd1;

    typedef logic [LEVEL_W-1:0] t_level;

    typedef struct packed {
        t_level blue;
        t_level green;
        t_level red;
    } t_rgb;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HEAD = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // Eight palette colors the head pixel fades toward.
    function automatic t_rgb palette_rgb(input logic [PAL_W-1:0] idx);
        t_rgb c;
        case (idx)
            3'd0:    c = '{red: 8'd15, green: 8'd15, blue: 8'd15};
            3'd1:    c = '{red: 8'd25, green: 8'd0,  blue: 8'd0};
            3'd2:    c = '{red: 8'd25, green: 8'd10, blue: 8'd0};
            3'd3:    c = '{red: 8'd10, green: 8'd25, blue: 8'd0};
            3'd4:    c = '{red: 8'd0,  green: 8'd25, blue: 8'd0};
            3'd5:    c = '{red: 8'd0,  green: 8'd10, blue: 8'd25};
            3'd6:    c = '{red: 8'd0,  green: 8'd0,  blue: 8'd25};
            3'd7:    c = '{red: 8'd10, green: 8'd0,  blue: 8'd25};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rfps_fade.sv
// One color channel of the head pixel stepping toward its palette target.
// Depends on rfps_pkg for the level and step widths.
`timescale 1ns / 1ps
`default_nettype none

module rfps_fade
    import rfps_pkg::*;
(
    input  wire t_level              i_level,
    input  wire t_level              i_target,
    input  wire logic [STEP_W-1:0]   i_step,
    output t_level                   o_level
);

    // Signed compare with room for a negative lower band edge.
    logic signed [LEVEL_W+1:0] lv;
    logic signed [LEVEL_W+1:0] tg;
    logic signed [LEVEL_W+1:0] st;
    logic signed [LEVEL_W+1:0] res;

    always_comb begin
        lv  = signed'({2'b00, i_level});
        tg  = signed'({2'b00, i_target});
        st  = signed'({2'b00, i_step});
        res = lv;
        // At most one of the two moves can apply, since the band is symmetric.
        if (lv < tg - st) begin
            res = lv + st;
        end else if (lv > tg + st) begin
            res = lv - st;
        end
        o_level = res[LEVEL_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/rainbow_fade_pixel_shifter.sv
// Rainbow fade pixel shifter: top level with the pixel memory, control and output stage.
// Depends on rfps_pkg and instantiates three rfps_fade channel units.
// The first pixel of a frame reaches m_axis through the head read, the head update state,
// the emit read into stage one and the output register; the remaining pixels follow one
// per cycle while m_axis_tready stays high. The time a frame takes is set by the single
// read port of the pixel memory; a tick with value zero is accepted without a frame.
// Reset (synchronous, active low) clears all pixels to zero through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rainbow_fade_pixel_shifter
    import rfps_pkg::*;
#(
    parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,

    // Configuration write port.
    input  wire                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_W-1:0]       i_cfg_data,

    // Tick items. tdata: [0] frame_tick, [7:1] zero.
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Pixel items. tdata: [5:0] pixel_index, [13:6] red_level, [21:14] green_level,
    // [29:22] blue_level, [31:30] zero. tlast: frame_last.
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);
    localparam logic [IDX_W:0]   DEPTH    = (IDX_W + 1)'(NUM_PIXELS);

    // The strip is a circular buffer. Logical pixel i lives at physical entry
    // (r_base + i) mod NUM_PIXELS, so a shift away from the head is a single
    // decrement of r_base together with one write of the new head pixel.

    t_state r_state;
    t_state n_state;

    logic [SEG_W-1:0]  r_seg_len;
    logic [STEP_W-1:0] r_fade_step;
    logic [PAL_W-1:0]  r_pal_idx;
    logic [SEG_W-1:0]  r_frame_cnt;
    logic [IDX_W-1:0]  r_base;
    logic [IDX_W-1:0]  r_rd_idx;

    // Pixel memory and its per-entry valid bits; an entry never written reads as black.
    t_rgb              mem [NUM_PIXELS];
    logic [NUM_PIXELS-1:0] r_ent_vld;
    t_rgb              r_rd_data;
    logic              r_rd_ok;

    // Stage one: read data in flight from the memory.
    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;

    // Stage two: output register.
    logic              r_o_vld;
    logic [IDX_W-1:0]  r_o_idx;
    t_rgb              r_o_rgb;
    logic              r_o_last;

    logic              tick_acc;
    logic              s2_load;
    logic              s1_adv;
    logic              mem_re;
    logic              mem_we;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  base_dec;
    logic [IDX_W:0]    phys_sum;
    logic [IDX_W-1:0]  phys_addr;
    t_rgb              head_old;
    t_rgb              head_new;
    t_rgb              target;
    logic              pal_wrap;

    // A new tick is taken only once the previous frame has left stage one, because the
    // head read of the next frame shares the read data register.
    assign s_axis_tready = (r_state == S_IDLE) && !r_s1_vld;
    assign tick_acc      = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];

    assign s2_load = r_s1_vld && (!r_o_vld || m_axis_tready);
    assign s1_adv  = !r_s1_vld || s2_load;

    always_comb begin
        phys_sum = {1'b0, r_base} + {1'b0, r_rd_idx};
        if (phys_sum >= DEPTH) begin
            phys_sum = phys_sum - DEPTH;
        end
        phys_addr = phys_sum[IDX_W-1:0];
        base_dec  = (r_base == '0) ? LAST_IDX : r_base - 1'b1;
    end

    assign mem_re = tick_acc || ((r_state == S_EMIT) && s1_adv);
    assign raddr  = (r_state == S_EMIT) ? phys_addr : r_base;
    assign mem_we = (r_state == S_HEAD);
    assign waddr  = base_dec;

    // The palette index is already updated when the head is faded.
    assign head_old = r_rd_ok ? r_rd_data : '0;
    assign target   = palette_rgb(r_pal_idx);

    rfps_fade u_fade_red (
        .i_level  (head_old.red),
        .i_target (target.red),
        .i_step   (r_fade_step),
        .o_level  (head_new.red)
    );

    rfps_fade u_fade_green (
        .i_level  (head_old.green),
        .i_target (target.green),
        .i_step   (r_fade_step),
        .o_level  (head_new.green)
    );

    rfps_fade u_fade_blue (
        .i_level  (head_old.blue),
        .i_target (target.blue),
        .i_step   (r_fade_step),
        .o_level  (head_new.blue)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_acc) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (s1_adv && (r_rd_idx == LAST_IDX)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The palette advances when the counter passes the segment length or reaches its top value.
    assign pal_wrap = (r_frame_cnt > r_seg_len) || (r_frame_cnt == FRAME_CNT_TOP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_len   <= SEG_LEN_RST;
            r_fade_step <= FADE_STEP_RST;
            r_pal_idx   <= PAL_IDX_RST;
            r_frame_cnt <= FRAME_CNT_RST;
            r_base      <= '0;
            r_rd_idx    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SEG_LEN:   r_seg_len   <= i_cfg_data[SEG_W-1:0];
                    CFG_FADE_STEP: r_fade_step <= i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (tick_acc) begin
                if (pal_wrap) begin
                    r_pal_idx   <= r_pal_idx + 1'b1;
                    r_frame_cnt <= FRAME_CNT_RST;
                end else begin
                    r_frame_cnt <= r_frame_cnt + 1'b1;
                end
            end

            if (r_state == S_HEAD) begin
                r_base   <= base_dec;
                r_rd_idx <= '0;
            end else if ((r_state == S_EMIT) && s1_adv) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= head_new;
        end
        if (mem_re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (mem_we) begin
                r_ent_vld[waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_ok <= r_ent_vld[raddr];
            end
        end
    end

    // Read pipeline and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && s1_adv) begin
                r_s1_vld <= 1'b1;
            end else if (s2_load) begin
                r_s1_vld <= 1'b0;
            end

            if (s2_load) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && s1_adv) begin
            r_s1_idx <= r_rd_idx;
        end
        if (s2_load) begin
            r_o_idx  <= r_s1_idx;
            r_o_rgb  <= r_rd_ok ? r_rd_data : '0;
            r_o_last <= (r_s1_idx == LAST_IDX);
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {2'b00, r_o_rgb.blue, r_o_rgb.green, r_o_rgb.red,
                            PIX_IDX_W'(r_o_idx)};

    // The head read must not be overwritten before the fade uses it.
    a_head_read_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |-> !r_s1_vld)
        else $error("pixel read in flight during head update");

    a_head_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |=> (r_state == S_EMIT) && (r_rd_idx == '0))
        else $error("emit sweep did not start at the head");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_o_idx == LAST_IDX)))
        else $error("frame end marker on wrong pixel");

    // The read index steps one past the last pixel when a sweep ends, so it is only
    // bounded while the sweep is running.
    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base <= LAST_IDX) && ((r_state != S_EMIT) || (r_rd_idx <= LAST_IDX)))
        else $error("circular buffer pointer out of range");

    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (r_frame_cnt != '0))
        else $error("frame counter reached zero");

endmodule

`default_nettype wire
